// ===== design/first_fit_block_allocator_assert.svh =====
// Assertion macros shared by the allocator checker.
// Needs nothing else; take it in by include.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/ffba_pkg.sv =====
// Shared constants, status codes and cell-chain types of the block allocator.
// Depends on nothing.
`default_nettype none
package ffba_pkg;

  localparam int TableDepth = 16;
  localparam int AddrW      = 16;
  localparam int SizeW      = AddrW + 1;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int EsizeW     = 16;
  localparam int EcntW      = 15;
  localparam int ProdW      = EsizeW + EcntW;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [2:0] StReused    = 3'd0;
  localparam logic [2:0] StFresh     = 3'd1;
  localparam logic [2:0] StHeapFull  = 3'd2;
  localparam logic [2:0] StTableFull = 3'd3;
  localparam logic [2:0] StNegCount  = 3'd4;
  localparam logic [2:0] StFreed     = 3'd5;
  localparam logic [2:0] StUnknown   = 3'd6;

  typedef struct packed {
    logic             valid;
    logic             op;
    logic             big;
    logic [SizeW-1:0] total;
    logic [AddrW-1:0] addr;
    logic             hit;
    logic [AddrW-1:0] base;
  } scan_tok_t;

  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] base;
    logic [SizeW-1:0] size;
  } cell_wr_t;

endpackage
`default_nettype wire

// ===== design/ffba_cell.sv =====
// One table entry of the allocator: base, size and in-use bit.
// Takes the scan item from its upper neighbor and hands it on in the following cycle.
// Depends on ffba_pkg.
`default_nettype none
module ffba_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ffba_pkg::IdxW-1:0]    idx_i,
  input  logic [ffba_pkg::CntW-1:0]    count_i,
  input  ffba_pkg::cell_wr_t           wr_i,
  input  ffba_pkg::scan_tok_t          tok_i,
  output ffba_pkg::scan_tok_t          tok_o
);
  import ffba_pkg::*;

  logic [AddrW-1:0] base_q;
  logic [SizeW-1:0] size_q;
  logic             use_q, use_d;
  scan_tok_t        tok_q, tok_d;
  logic             live;

  always_comb begin
    tok_d = tok_i;
    use_d = use_q;
    live  = {1'b0, idx_i} < count_i;
    if (tok_i.valid && live) begin
      if (tok_i.op == OpFree) begin
        if (base_q == tok_i.addr) begin
          use_d     = 1'b0;
          tok_d.hit = 1'b1;
        end
      end else if (!tok_i.hit && !use_q && !tok_i.big && (tok_i.total <= size_q)) begin
        use_d      = 1'b1;
        tok_d.hit  = 1'b1;
        tok_d.base = base_q;
      end
    end
    if (wr_i.en && (wr_i.idx == idx_i)) begin
      use_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= 1'b0;
      tok_q <= '0;
    end else begin
      use_q <= use_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == idx_i)) begin
      base_q <= wr_i.base;
      size_q <= wr_i.size;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

// ===== design/first_fit_block_allocator.sv =====
// First-fit block allocator with a bump pointer over a configurable heap.
// Input channel (in_valid_i/in_ready_o): op_i, element_size_i, element_count_i,
// address_i. Output channel (out_valid_o/out_ready_i): status_o, block_address_o.
// One item at a time. An accepted item first passes the multiplier register,
// then its scan item walks the chain of table cells from the newest
// entry to the oldest, one cell per cycle, along the chain of 16 cells;
// the SFin state then writes the result and appends any fresh block.
// An allocate with a negative count skips the chain.
// A new item is taken in the cycle after the last one's result is loaded.
// The result sits in an output register: the next item is accepted and
// worked while it waits; if the receiver still stalls when that next result
// is ready, the block holds it until the register frees.
// heap_limit is written via cfg_we_i/cfg_wdata_i; the user must write it only while idle (not enforced).
// Reset empties the table, zeroes the bump pointer and sets heap_limit to 65536.
// Depends on ffba_pkg and ffba_cell.
`default_nettype none
module first_fit_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffba_pkg::SizeW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [ffba_pkg::EsizeW-1:0]   element_size_i,
  input  logic signed [15:0]            element_count_i,
  input  logic [ffba_pkg::AddrW-1:0]    address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [ffba_pkg::AddrW-1:0]    block_address_o
);
  import ffba_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SMul  = 2'd1;
  localparam logic [1:0] SScan = 2'd2;
  localparam logic [1:0] SFin  = 2'd3;
  localparam logic [SizeW-1:0] HeapSpan = {1'b1, {AddrW{1'b0}}};

  logic [1:0]        state_q, state_d;
  logic [SizeW-1:0]  heap_limit_q;
  logic [SizeW-1:0]  bump_q;
  logic [CntW-1:0]   count_q;
  logic              op_q, neg_q;
  logic [EsizeW-1:0] esize_q;
  logic [EcntW-1:0]  ecnt_q;
  logic [AddrW-1:0]  addr_q;
  logic [ProdW-1:0]  prod_q;
  logic              first_q;
  logic              hit_q;
  logic [AddrW-1:0]  hbase_q;
  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [AddrW-1:0]  baddr_q;

  scan_tok_t         tok [TableDepth+1];
  cell_wr_t          wr;
  logic [SizeW-1:0]  total;
  logic              big;
  logic [SizeW-1:0]  limit_eff;
  logic [SizeW:0]    sum;
  logic              heap_full;
  logic [2:0]        res_status;
  logic [AddrW-1:0]  res_addr;
  logic              append;
  logic              fin_go;
  logic              in_acc;

  assign in_ready_o = (state_q == SIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign total      = prod_q[SizeW-1:0];
  assign big        = |prod_q[ProdW-1:SizeW];
  assign limit_eff  = (heap_limit_q > HeapSpan) ? HeapSpan : heap_limit_q;
  assign sum        = {1'b0, bump_q} + {1'b0, total};
  assign heap_full  = bump_q[AddrW] | big | (sum > {1'b0, limit_eff});
  assign fin_go     = (state_q == SFin) && (!out_valid_q || out_ready_i);

  always_comb begin
    res_status = StUnknown;
    res_addr   = '0;
    append     = 1'b0;
    if (op_q == OpFree) begin
      res_status = hit_q ? StFreed : StUnknown;
    end else if (neg_q) begin
      res_status = StNegCount;
    end else if (hit_q) begin
      res_status = StReused;
      res_addr   = hbase_q;
    end else if (heap_full) begin
      res_status = StHeapFull;
    end else if (count_q == CntW'(TableDepth)) begin
      res_status = StTableFull;
    end else begin
      res_status = StFresh;
      res_addr   = bump_q[AddrW-1:0];
      append     = 1'b1;
    end
  end

  always_comb begin
    wr.en   = fin_go && append;
    wr.idx  = count_q[IdxW-1:0];
    wr.base = bump_q[AddrW-1:0];
    wr.size = total;
  end

  always_comb begin
    tok[TableDepth].valid = (state_q == SScan) && first_q;
    tok[TableDepth].op    = op_q;
    tok[TableDepth].big   = big;
    tok[TableDepth].total = total;
    tok[TableDepth].addr  = addr_q;
    tok[TableDepth].hit   = 1'b0;
    tok[TableDepth].base  = '0;
  end

  for (genvar k = 0; k < TableDepth; k++) begin : g_cell
    ffba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IdxW'(k)),
      .count_i (count_q),
      .wr_i    (wr),
      .tok_i   (tok[k+1]),
      .tok_o   (tok[k])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (in_acc) state_d = SMul;
      SMul:  state_d = ((op_q == OpAlloc) && neg_q) ? SFin : SScan;
      SScan: if (tok[0].valid) state_d = SFin;
      SFin:  if (fin_go) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      heap_limit_q <= HeapSpan;
      bump_q       <= '0;
      count_q      <= '0;
      first_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= (state_q == SMul);
      if (cfg_we_i) begin
        heap_limit_q <= cfg_wdata_i;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fin_go && append) begin
        bump_q  <= sum[SizeW-1:0];
        count_q <= count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_i;
      neg_q   <= element_count_i[15];
      esize_q <= element_size_i;
      ecnt_q  <= element_count_i[EcntW-1:0];
      addr_q  <= address_i;
    end
    if (state_q == SMul) begin
      prod_q <= ProdW'(esize_q) * ProdW'(ecnt_q);
    end
    if (state_q == SMul) begin
      hit_q <= 1'b0;
    end else if ((state_q == SScan) && tok[0].valid) begin
      hit_q   <= tok[0].hit;
      hbase_q <= tok[0].base;
    end
    if (fin_go) begin
      status_q <= res_status;
      baddr_q  <= res_addr;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign block_address_o = baddr_q;

endmodule
`default_nettype wire

// ===== design/ffba_checker.sv =====
// Port-level checks of the block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_assert.svh.
`default_nettype none
`include "first_fit_block_allocator_assert.svh"
module ffba_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [2:0]                    status_o,
  input  logic [ffba_pkg::AddrW-1:0]    block_address_o
);
  import ffba_pkg::*;

  `FFBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(status_o) && $stable(block_address_o))
  `FFBA_ASSERT_NOW(a_addr_zero, clk_i, rst_ni,
    out_valid_o && (status_o != StReused) && (status_o != StFresh), block_address_o == '0)
  `FFBA_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `FFBA_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni,
    in_valid_i && in_ready_o && !out_valid_o, !out_valid_o)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .block_address_o (block_address_o)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for first_fit_block_allocator: a driver and a monitor
// around the block, with a built-in allocator predictor and per-field checks.
// Depends on ffba_pkg and the allocator RTL only.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam int              CycleLimit = 400000;
  localparam int              PhaseItems = 105;
  localparam int              HoldCycles = 400;
  localparam longint unsigned HeapSpan   = 64'd1 << AddrW;

  typedef struct {
    logic               op;
    logic [EsizeW-1:0]  elem_size;
    logic signed [15:0] elem_count;
    logic [AddrW-1:0]   addr;
  } alloc_req_t;

  typedef struct {
    logic [2:0]       status;
    logic [AddrW-1:0] block_address;
  } grant_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [SizeW-1:0]   cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic               op_i            = OpAlloc;
  logic [EsizeW-1:0]  element_size_i  = '0;
  logic signed [15:0] element_count_i = '0;
  logic [AddrW-1:0]   address_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [2:0]         status_o;
  logic [AddrW-1:0]   block_address_o;

  alloc_req_t pending_items[$];
  grant_t     expected_grants[$];
  alloc_req_t cur_item;
  grant_t     next_grant;

  logic [AddrW-1:0] tbl_base [TableDepth];
  logic [SizeW-1:0] tbl_size [TableDepth];
  logic             tbl_busy [TableDepth] = '{default: 1'b0};
  int               tbl_count    = 0;
  logic [SizeW-1:0] bump_ptr     = '0;
  logic [SizeW-1:0] heap_limit_q = 17'h10000;

  int tx_burst_left    = 0;
  int tx_gap_left      = 0;
  int rx_run_left      = 0;
  int rx_stall_left    = 0;
  int rx_hold_left     = 0;
  int rx_hold_requests = 0;
  int rx_hold_served   = 0;
  int items_sent       = 0;
  int results_checked  = 0;
  int mismatches       = 0;
  int limits_written   = 0;
  int cycle_count      = 0;
  int outcome_count [7] = '{default: 0};

  first_fit_block_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .element_size_i  (element_size_i),
    .element_count_i (element_count_i),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .block_address_o (block_address_o)
  );

  always begin
    #5ns clk_i = ~clk_i;
  end

  function automatic grant_t compute_grant(alloc_req_t r);
    grant_t          g;
    logic            hit;
    longint unsigned need;
    longint unsigned lim;
    g.status        = StUnknown;
    g.block_address = '0;
    hit             = 1'b0;
    if (r.op == OpFree) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_base[i] == r.addr) begin
          tbl_busy[i] = 1'b0;
          hit         = 1'b1;
        end
      end
      g.status = hit ? StFreed : StUnknown;
      return g;
    end
    if (r.elem_count[15]) begin
      g.status = StNegCount;
      return g;
    end
    need = r.elem_size;
    need = need * r.elem_count[14:0];
    // newest block first
    for (int k = tbl_count - 1; k >= 0; k--) begin
      if (!tbl_busy[k] && need <= tbl_size[k]) begin
        tbl_busy[k]     = 1'b1;
        g.status        = StReused;
        g.block_address = tbl_base[k];
        return g;
      end
    end
    lim = (heap_limit_q > HeapSpan) ? HeapSpan : heap_limit_q;
    if (bump_ptr >= HeapSpan || bump_ptr + need > lim) begin
      g.status = StHeapFull;
      return g;
    end
    if (tbl_count >= TableDepth) begin
      g.status = StTableFull;
      return g;
    end
    tbl_base[tbl_count] = bump_ptr[AddrW-1:0];
    tbl_size[tbl_count] = need[SizeW-1:0];
    tbl_busy[tbl_count] = 1'b1;
    tbl_count++;
    g.status        = StFresh;
    g.block_address = bump_ptr[AddrW-1:0];
    bump_ptr        = bump_ptr + need[SizeW-1:0];
    return g;
  endfunction

  function automatic void queue_item(logic op, logic [15:0] es, logic [15:0] ec,
                                     logic [15:0] a);
    alloc_req_t r;
    r.op         = op;
    r.elem_size  = es;
    r.elem_count = ec;
    r.addr       = a;
    pending_items.push_back(r);
  endfunction

  function automatic alloc_req_t random_request();
    alloc_req_t r;
    int         pick;
    int         k;
    int         target;
    pick         = $urandom_range(0, 99);
    r.op         = OpAlloc;
    r.elem_size  = EsizeW'($urandom);
    r.elem_count = 16'($urandom);
    r.addr       = AddrW'($urandom);
    if (pick < 15) begin
      r.op = 1'($urandom_range(0, 1));
      return r;
    end
    if (pick < 40) begin
      r.op = OpFree;
      if (tbl_count > 0 && $urandom_range(0, 9) != 0) begin
        r.addr = tbl_base[$urandom_range(0, tbl_count - 1)];
      end
      return r;
    end
    if (pick < 47) begin
      r.elem_count[15] = 1'b0;
      return r;
    end
    // aim near the size of a known block (up to one past or three below), or at a random size
    if (tbl_count > 0 && $urandom_range(0, 1) == 1) begin
      k      = $urandom_range(0, tbl_count - 1);
      target = int'(tbl_size[k]) + int'($urandom_range(0, 1)) - int'($urandom_range(0, 3));
      if (target < 0) target = 0;
    end else begin
      target = $urandom_range(0, 3000);
    end
    if (target > 65535) target = 65535;
    r.elem_size  = target[15:0];
    r.elem_count = 16'sd1;
    case ($urandom_range(0, 3))
      1: begin
        if (target <= 32767) begin
          r.elem_size  = 16'd1;
          r.elem_count = target[15:0];
        end
      end
      2: begin
        if (target[0] == 1'b0 && target > 0) begin
          r.elem_size  = 16'd2;
          r.elem_count = 16'(target / 2);
        end
      end
      3: begin
        if ($urandom_range(0, 1) == 1) begin
          r.elem_count = 16'sd0;
        end else begin
          r.elem_size  = 16'd0;
          r.elem_count = 16'($urandom_range(0, 32767));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic write_heap_limit(logic [SizeW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    heap_limit_q = v;
    limits_written++;
  endtask

  task automatic drain_results();
    while (pending_items.size() != 0 || in_valid_i || expected_grants.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TableDepth + 8) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_grants.push_back(compute_grant(cur_item));
        outcome_count[expected_grants[$].status]++;
        items_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap_left > 0 || pending_items.size() == 0) begin
          if (tx_gap_left > 0) tx_gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          op_i            <= cur_item.op;
          element_size_i  <= cur_item.elem_size;
          element_count_i <= cur_item.elem_count;
          address_i       <= cur_item.addr;
          in_valid_i      <= 1'b1;
          if (tx_burst_left > 0) begin
            tx_burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            tx_burst_left = $urandom_range(20, 40);
            tx_gap_left   = 0;
          end else begin
            tx_burst_left = $urandom_range(0, 8);
            tx_gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_grants.size() == 0) begin
          $error("result with no item pending: status %0d, block_address %0h",
                 status_o, block_address_o);
          mismatches++;
        end else begin
          next_grant = expected_grants.pop_front();
          results_checked++;
          if (status_o !== next_grant.status) begin
            $error("status: expected %0d, actual %0d", next_grant.status, status_o);
            mismatches++;
          end
          if (block_address_o !== next_grant.block_address) begin
            $error("block_address: expected %0h, actual %0h",
                   next_grant.block_address, block_address_o);
            mismatches++;
          end
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_hold_served != rx_hold_requests) begin
        rx_hold_served++;
        rx_hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_run_left > 0) begin
          rx_run_left--;
        end else begin
          rx_run_left   = $urandom_range(1, 24);
          rx_stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_grants.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [SizeW-1:0] lim;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty heap: zero size, heap full, negative count, free cases
    write_heap_limit('0);
    queue_item(OpAlloc, 16'h0000, 16'd7, 16'h0000);
    queue_item(OpAlloc, 16'h0001, 16'd1, 16'h0000);
    queue_item(OpAlloc, 16'hFFFF, 16'h8000, 16'hFFFF);
    queue_item(OpAlloc, 16'h0001, 16'hFFFF, 16'h0000);
    queue_item(OpFree, 16'h0000, 16'h0000, 16'h1234);
    queue_item(OpFree, 16'hFFFF, 16'h7FFF, 16'h0000);
    queue_item(OpFree, 16'h0000, 16'h0000, 16'h0000);
    queue_item(OpAlloc, 16'h0000, 16'h0000, 16'h0000);
    drain_results();

    // oversized limit: huge request, reuse order, blocks that share a base
    write_heap_limit(17'h1FFFF);
    queue_item(OpAlloc, 16'hFFFF, 16'h7FFF, 16'h0000);
    queue_item(OpAlloc, 16'd16, 16'd4, 16'h0000);
    queue_item(OpAlloc, 16'd1, 16'd100, 16'h0000);
    queue_item(OpFree, 16'h0000, 16'h0000, 16'd64);
    queue_item(OpAlloc, 16'd10, 16'd10, 16'h0000);
    queue_item(OpFree, 16'h0000, 16'h0000, 16'h0000);
    queue_item(OpAlloc, 16'd1, 16'd1, 16'h0000);
    queue_item(OpAlloc, 16'd0, 16'd0, 16'h0000);
    queue_item(OpFree, 16'h0000, 16'h0000, 16'hFFFF);
    queue_item(OpAlloc, 16'd0, 16'h7FFF, 16'h0000);
    drain_results();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       lim = 17'h10000;
        1:       lim = 17'h1FFFF;
        2:       lim = SizeW'($urandom_range(0, 17'h1FFFF));
        3:       lim = '0;
        4:       lim = SizeW'(bump_ptr + $urandom_range(0, 4000));
        default: lim = 17'h0FFFF;
      endcase
      write_heap_limit(lim);
      if (p == 1) rx_hold_requests++;
      for (int n = 0; n < PhaseItems; n++) begin
        while (pending_items.size() >= 3) @(posedge clk_i);
        pending_items.push_back(random_request());
      end
      drain_results();
    end

    if (expected_grants.size() != 0) begin
      $error("%0d expected results never arrived", expected_grants.size());
      mismatches++;
    end
    $display("Run covered %0d items, %0d checked results, %0d heap limit settings",
             items_sent, results_checked, limits_written);
    $display("Outcomes: reused %0d fresh %0d heap-full %0d table-full %0d negative %0d %s",
             outcome_count[StReused], outcome_count[StFresh], outcome_count[StHeapFull],
             outcome_count[StTableFull], outcome_count[StNegCount],
             $sformatf("freed %0d unknown %0d", outcome_count[StFreed],
                       outcome_count[StUnknown]));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/ffba_pkg.sv
design/ffba_cell.sv
design/first_fit_block_allocator.sv
design/ffba_checker.sv
dv/testbench.sv
